FILE: sv/vdp_pkg.sv
// Shared types and constants of the video processor port and DMA engine.
// No dependencies; every other file imports it.
package vdp_pkg;

    localparam int REG_COUNT   = 24;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int VRAM_BYTES  = 65536;
    localparam int VRAM_AW     = $clog2(VRAM_BYTES);
    localparam int CRAM_DEPTH  = 64;
    localparam int VSRAM_DEPTH = 40;

    // Item commands
    localparam logic [2:0] CMD_READ_BYTE  = 3'd0;
    localparam logic [2:0] CMD_READ_WORD  = 3'd1;
    localparam logic [2:0] CMD_WRITE_BYTE = 3'd2;
    localparam logic [2:0] CMD_WRITE_WORD = 3'd3;
    localparam logic [2:0] CMD_TICK       = 3'd4;

    // Access codes, low nibble
    localparam logic [3:0] CODE_VRAM_RD  = 4'd0;
    localparam logic [3:0] CODE_VRAM_WR  = 4'd1;
    localparam logic [3:0] CODE_CRAM_WR  = 4'd3;
    localparam logic [3:0] CODE_VSRAM_RD = 4'd4;
    localparam logic [3:0] CODE_VSRAM_WR = 4'd5;
    localparam logic [3:0] CODE_CRAM_RD  = 4'd8;

    // DMA modes (register 23, bits 7:6)
    localparam logic [1:0] DMA_FILL = 2'd2;
    localparam logic [1:0] DMA_COPY = 2'd3;

    // Mode register indexes
    localparam int REG_MODE1   = 0;
    localparam int REG_MODE2   = 1;
    localparam int REG_HINT    = 10;
    localparam int REG_AUTOINC = 15;
    localparam int REG_LEN_LO  = 19;
    localparam int REG_LEN_HI  = 20;
    localparam int REG_SRC_LO  = 21;
    localparam int REG_SRC_HI  = 22;
    localparam int REG_DMA     = 23;

    // Configuration register indexes
    localparam logic [1:0] CFG_PAL_MODE   = 2'd0;
    localparam logic [1:0] CFG_LINES_NTSC = 2'd1;
    localparam logic [1:0] CFG_LINES_PAL  = 2'd2;

    localparam logic [15:0] STATUS_BASE = 16'h0300;
    localparam logic [5:0]  VSRAM_MASK  = 6'h27;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

endpackage

FILE: sv/vdp_rem_unit.sv
// Restoring remainder unit, one quotient bit per cycle (9-bit dividend).
// Depends on vdp_pkg for the status struct.
module vdp_rem_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [8:0]            i_dividend,
    input  logic [8:0]            i_divisor,
    output vdp_pkg::t_rem_status  o_status
);
    import vdp_pkg::*;

    logic       r_busy;
    logic [3:0] r_cnt;
    logic [8:0] r_num;
    logic [8:0] r_den;
    logic [7:0] r_rem;
    logic       r_done;
    logic       r_zero;
    logic [8:0] trial;
    logic [8:0] step;

    always_comb begin
        trial = {r_rem, r_num[8]};
        step  = (trial >= r_den) ? trial - r_den : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= step[7:0];
                r_num <= {r_num[7:0], 1'b0};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd8) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_zero <= (step == 9'd0);
                end
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.zero = r_zero;

endmodule

FILE: sv/vdp_port_and_dma_engine.sv
// Top level: video processor CPU port with DMA fill and VRAM copy engine.
// Depends on vdp_pkg and vdp_rem_unit.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------------
//  item in   | start & !busy         | i_cmd, i_port_offset, i_write_value, i_line_number
//  result    | o_done (one cycle)    | o_read_data, o_vblank_start, o_hint_fire
//  config    | psel&penable&pwrite   | paddr, pwdata (prdata returns the register)
//
// Simple items finish straight from S_IDLE; a VRAM word write passes S_WR_HI and S_WR_LO,
// a data read S_RD_A, S_RD_B and S_RD_C, and a tick that tests the H-interrupt waits in
// S_DIV (one remainder bit per cycle). DMA fill runs one VRAM byte per cycle, VRAM copy
// reads each byte in S_COPY_RD and writes it in S_COPY_WR, for up to 65536 bytes. After
// reset a clearing pass over all 65536 VRAM addresses zeroes VRAM, CRAM and VSRAM; busy
// stays high meanwhile. The receiver cannot stall: each result shows for one cycle on o_done.
module vdp_port_and_dma_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [4:0]  i_port_offset,
    input  logic [15:0] i_write_value,
    input  logic [8:0]  i_line_number,
    output logic        o_done,
    output logic [15:0] o_read_data,
    output logic        o_vblank_start,
    output logic        o_hint_fire,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vdp_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_RD_A    = 11'b000_0000_0100,
        S_RD_B    = 11'b000_0000_1000,
        S_RD_C    = 11'b000_0001_0000,
        S_WR_HI   = 11'b000_0010_0000,
        S_WR_LO   = 11'b000_0100_0000,
        S_FILL    = 11'b000_1000_0000,
        S_COPY_RD = 11'b001_0000_0000,
        S_COPY_WR = 11'b010_0000_0000,
        S_DIV     = 11'b100_0000_0000
    } t_state;

    // Configuration
    logic       r_pal_mode;
    logic [8:0] r_lines_ntsc;
    logic [8:0] r_lines_pal;

    // Sequencer and port state
    t_state      r_state, n_state;
    logic [15:0] r_clr, n_clr;
    logic        r_word_pending, n_word_pending;
    logic        r_byte_pending, n_byte_pending;
    logic [15:0] r_first, n_first;
    logic [15:0] r_addr, n_addr;
    logic [5:0]  r_code, n_code;
    logic [7:0]  r_autoinc, n_autoinc;
    logic [7:0]  r_mode_regs [REG_COUNT];
    logic [7:0]  n_mode_regs [REG_COUNT];
    logic [7:0]  r_vcount, n_vcount;
    logic        r_in_vblank, n_in_vblank;
    logic        r_vint, n_vint;
    logic        r_fill_armed, n_fill_armed;
    logic [15:0] r_fill_word, n_fill_word;
    logic [16:0] r_cnt, n_cnt;
    logic [15:0] r_src, n_src;
    logic        r_byte_mode, n_byte_mode;
    logic        r_byte_odd, n_byte_odd;
    logic [7:0]  r_hi_byte, n_hi_byte;

    // Result
    logic        r_done, n_done;
    logic [15:0] r_rd, n_rd;
    logic        r_vs, n_vs;
    logic        r_hi, n_hi;

    // Memories
    logic [7:0]  vram  [VRAM_BYTES];
    logic [15:0] cram  [CRAM_DEPTH];
    logic [15:0] vsram [VSRAM_DEPTH];
    logic [7:0]  vram_q;
    logic [15:0] cram_q;
    logic [15:0] vsram_q;
    logic                vram_we;
    logic [VRAM_AW-1:0]  vram_waddr;
    logic [7:0]          vram_wdata;
    logic [VRAM_AW-1:0]  vram_raddr;
    logic                cram_we;
    logic [5:0]          cram_waddr;
    logic [15:0]         cram_wdata;
    logic                vsram_we;
    logic [5:0]          vsram_waddr;
    logic [15:0]         vsram_wdata;
    logic [5:0]          vsram_raddr;

    // Remainder unit
    logic        rem_start;
    logic [8:0]  rem_divisor;
    t_rem_status rem_status;

    logic apb_wr;
    assign apb_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            CFG_PAL_MODE:   prdata = {31'd0, r_pal_mode};
            CFG_LINES_NTSC: prdata = {23'd0, r_lines_ntsc};
            CFG_LINES_PAL:  prdata = {23'd0, r_lines_pal};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_mode   <= 1'b0;
            r_lines_ntsc <= 9'd224;
            r_lines_pal  <= 9'd240;
        end else if (apb_wr) begin
            case (paddr[3:2])
                CFG_PAL_MODE:   r_pal_mode   <= pwdata[0];
                CFG_LINES_NTSC: r_lines_ntsc <= pwdata[8:0];
                CFG_LINES_PAL:  r_lines_pal  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    assign rem_divisor = {1'b0, r_mode_regs[REG_HINT]} + 9'd1;

    vdp_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (i_line_number),
        .i_divisor  (rem_divisor),
        .o_status   (rem_status)
    );

    // Read addresses: the second byte of a data read, the copy source, else the access address
    always_comb begin
        case (r_state)
            S_RD_B:    vram_raddr = r_addr + 16'd1;
            S_COPY_RD: vram_raddr = r_src;
            default:   vram_raddr = r_addr;
        endcase
    end
    assign vsram_raddr = r_addr[6:1] & VSRAM_MASK;

    always_ff @(posedge i_clk) begin
        if (vram_we) vram[vram_waddr] <= vram_wdata;
        vram_q <= vram[vram_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cram_we) cram[cram_waddr] <= cram_wdata;
        cram_q <= cram[r_addr[6:1]];
    end

    always_ff @(posedge i_clk) begin
        if (vsram_we) vsram[vsram_waddr] <= vsram_wdata;
        vsram_q <= vsram[vsram_raddr];
    end

    // Main sequencer
    always_comb begin
        logic        do_dwrite;
        logic        do_cword;
        logic        do_cbyte;
        logic        do_dread;
        logic        start_dma;
        logic        reg_we;
        logic [15:0] dval;
        logic [15:0] wreg;
        logic [15:0] rword;
        logic [8:0]  act;
        logic [16:0] len;
        logic        advance;
        logic        finish_dma;

        do_dwrite  = 1'b0;
        do_cword   = 1'b0;
        do_cbyte   = 1'b0;
        do_dread   = 1'b0;
        start_dma  = 1'b0;
        reg_we     = 1'b0;
        dval       = i_write_value;
        wreg       = i_write_value;
        rword      = 16'd0;
        act        = r_pal_mode ? r_lines_pal : r_lines_ntsc;
        len        = ({r_mode_regs[REG_LEN_HI], r_mode_regs[REG_LEN_LO]} == 16'd0)
                     ? 17'h10000
                     : {1'b0, r_mode_regs[REG_LEN_HI], r_mode_regs[REG_LEN_LO]};
        advance    = 1'b0;
        finish_dma = 1'b0;

        n_state        = r_state;
        n_clr          = r_clr;
        n_word_pending = r_word_pending;
        n_byte_pending = r_byte_pending;
        n_first        = r_first;
        n_addr         = r_addr;
        n_code         = r_code;
        n_autoinc      = r_autoinc;
        n_mode_regs    = r_mode_regs;
        n_vcount       = r_vcount;
        n_in_vblank    = r_in_vblank;
        n_vint         = r_vint;
        n_fill_armed   = r_fill_armed;
        n_fill_word    = r_fill_word;
        n_cnt          = r_cnt;
        n_src          = r_src;
        n_byte_mode    = r_byte_mode;
        n_byte_odd     = r_byte_odd;
        n_hi_byte      = r_hi_byte;
        n_done         = 1'b0;
        n_rd           = r_rd;
        n_vs           = r_vs;
        n_hi           = r_hi;

        vram_we     = 1'b0;
        vram_waddr  = r_addr;
        vram_wdata  = r_fill_word[15:8];
        cram_we     = 1'b0;
        cram_waddr  = r_addr[6:1];
        cram_wdata  = i_write_value;
        vsram_we    = 1'b0;
        vsram_waddr = r_addr[6:1] & VSRAM_MASK;
        vsram_wdata = i_write_value;
        rem_start   = 1'b0;

        case (r_state)
            S_CLEAR: begin
                // Zero one entry of each memory per cycle (VSRAM only below its depth)
                vram_we     = 1'b1;
                vram_waddr  = r_clr;
                vram_wdata  = 8'd0;
                cram_we     = 1'b1;
                cram_waddr  = r_clr[5:0];
                cram_wdata  = 16'd0;
                vsram_we    = ({26'd0, r_clr[5:0]} < VSRAM_DEPTH);
                vsram_waddr = r_clr[5:0];
                vsram_wdata = 16'd0;
                n_clr       = r_clr + 16'd1;
                if (r_clr == 16'hFFFF) n_state = S_IDLE;
            end

            S_IDLE: begin
                if (start) begin
                    // Most items finish here; those that move on to another state clear n_done
                    n_done = 1'b1;
                    n_rd   = 16'd0;
                    n_vs   = 1'b0;
                    n_hi   = 1'b0;
                    case (i_cmd)
                        CMD_READ_BYTE: begin
                            if (i_port_offset < 5'd4) begin
                                do_dread    = 1'b1;
                                n_byte_mode = 1'b1;
                                n_byte_odd  = i_port_offset[0];
                            end else if (i_port_offset == 5'd8) begin
                                n_rd = 16'd0;
                            end else if (i_port_offset == 5'd9) begin
                                n_rd = {8'd0, r_vcount};
                            end else begin
                                n_rd = 16'h00FF;
                            end
                        end
                        CMD_READ_WORD: begin
                            case (i_port_offset[4:1])
                                4'd0, 4'd1: begin
                                    do_dread    = 1'b1;
                                    n_byte_mode = 1'b0;
                                end
                                4'd2, 4'd3: begin
                                    // Status read clears the interrupt and pending flags
                                    n_rd = STATUS_BASE | {8'd0, r_vint, 3'd0, r_in_vblank,
                                                          2'd0, r_pal_mode};
                                    n_vint         = 1'b0;
                                    n_word_pending = 1'b0;
                                    n_byte_pending = 1'b0;
                                end
                                4'd4:    n_rd = {r_vcount, 8'd0};
                                default: n_rd = 16'hFFFF;
                            endcase
                        end
                        CMD_WRITE_BYTE: begin
                            if (i_port_offset < 5'd2) begin
                                do_dwrite = 1'b1;
                                dval = i_port_offset[0] ? {8'd0, i_write_value[7:0]}
                                                        : {i_write_value[7:0], 8'd0};
                            end else if (i_port_offset < 5'd8) begin
                                do_cbyte = 1'b1;
                            end
                        end
                        CMD_WRITE_WORD: begin
                            case (i_port_offset[4:1])
                                4'd0, 4'd1: do_dwrite = 1'b1;
                                4'd2, 4'd3: do_cword  = 1'b1;
                                default: ;
                            endcase
                        end
                        CMD_TICK: begin
                            n_vcount    = i_line_number[7:0];
                            n_in_vblank = (i_line_number >= act);
                            n_vs        = (i_line_number == act);
                            if (i_line_number == act) n_vint = 1'b1;
                            if (r_mode_regs[REG_MODE1][4] && (i_line_number < act)) begin
                                rem_start = 1'b1;
                                n_done    = 1'b0;
                                n_state   = S_DIV;
                            end
                        end
                        default: ;
                    endcase

                    if (do_dread) begin
                        n_done  = 1'b0;
                        n_state = S_RD_A;
                    end

                    if (do_dwrite) begin
                        n_fill_word = dval;
                        if (r_fill_armed) begin
                            // The armed fill fires: this write is not stored
                            n_fill_armed = 1'b0;
                            start_dma    = 1'b1;
                        end else begin
                            case (r_code[3:0])
                                CODE_VRAM_WR: begin
                                    n_done  = 1'b0;
                                    n_state = S_WR_HI;
                                end
                                CODE_CRAM_WR: begin
                                    cram_we    = 1'b1;
                                    cram_wdata = dval;
                                    advance    = 1'b1;
                                end
                                CODE_VSRAM_WR: begin
                                    vsram_we    = 1'b1;
                                    vsram_wdata = dval;
                                    advance     = 1'b1;
                                end
                                default: advance = 1'b1;
                            endcase
                        end
                    end

                    if (do_cword) begin
                        if (r_word_pending) begin
                            // Second half of an address/code command
                            n_word_pending = 1'b0;
                            n_code = {i_write_value[7:4], r_first[15:14]};
                            n_addr = {i_write_value[1:0], r_first[13:0]};
                            if (i_write_value[7]) begin
                                if (r_mode_regs[REG_DMA][7:6] == DMA_FILL) n_fill_armed = 1'b1;
                                else start_dma = 1'b1;
                            end
                        end else if (i_write_value[15:14] == 2'b10) begin
                            reg_we = 1'b1;
                            wreg   = i_write_value;
                        end else begin
                            n_first        = i_write_value;
                            n_word_pending = 1'b1;
                        end
                    end

                    if (do_cbyte) begin
                        if (!r_byte_pending) begin
                            n_first        = {8'd0, i_write_value[7:0]};
                            n_byte_pending = 1'b1;
                        end else begin
                            n_byte_pending = 1'b0;
                            wreg   = {r_first[7:0], i_write_value[7:0]};
                            reg_we = (wreg[15:14] == 2'b10);
                        end
                    end

                    if (reg_we && ({27'd0, wreg[12:8]} < REG_COUNT)) begin
                        n_mode_regs[wreg[REG_IDX_W+7:8]] = wreg[7:0];
                        if (wreg[12:8] == 5'(REG_AUTOINC)) n_autoinc = wreg[7:0];
                    end

                    if (start_dma) begin
                        case (r_mode_regs[REG_DMA][7:6])
                            DMA_FILL: begin
                                n_cnt   = len;
                                n_done  = 1'b0;
                                n_state = S_FILL;
                            end
                            DMA_COPY: begin
                                n_cnt   = len;
                                n_src   = {r_mode_regs[REG_SRC_HI], r_mode_regs[REG_SRC_LO]};
                                n_done  = 1'b0;
                                n_state = S_COPY_RD;
                            end
                            default: finish_dma = 1'b1;
                        endcase
                    end
                end
            end

            S_RD_A: n_state = S_RD_B;

            S_RD_B: begin
                n_hi_byte = vram_q;
                n_state   = S_RD_C;
            end

            S_RD_C: begin
                case (r_code[3:0])
                    CODE_VRAM_RD:  rword = {r_hi_byte, vram_q};
                    CODE_CRAM_RD:  rword = cram_q;
                    CODE_VSRAM_RD: rword = vsram_q;
                    default:       rword = 16'd0;
                endcase
                if (r_byte_mode) n_rd = r_byte_odd ? {8'd0, rword[7:0]} : {8'd0, rword[15:8]};
                else             n_rd = rword;
                advance = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            S_WR_HI: begin
                vram_we    = 1'b1;
                vram_wdata = r_fill_word[15:8];
                n_state    = S_WR_LO;
            end

            S_WR_LO: begin
                vram_we    = 1'b1;
                vram_waddr = r_addr + 16'd1;
                vram_wdata = r_fill_word[7:0];
                advance    = 1'b1;
                n_done     = 1'b1;
                n_state    = S_IDLE;
            end

            S_FILL: begin
                vram_we = (r_code[3:0] == CODE_VRAM_WR);
                advance = 1'b1;
                n_cnt   = r_cnt - 17'd1;
                if (r_cnt == 17'd1) begin
                    finish_dma = 1'b1;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            S_COPY_RD: n_state = S_COPY_WR;

            S_COPY_WR: begin
                vram_we    = 1'b1;
                vram_wdata = vram_q;
                n_src      = r_src + 16'd1;
                advance    = 1'b1;
                n_cnt      = r_cnt - 17'd1;
                if (r_cnt == 17'd1) begin
                    finish_dma = 1'b1;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_COPY_RD;
                end
            end

            S_DIV: begin
                if (rem_status.done) begin
                    n_hi    = rem_status.zero;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // Step the access address by the auto-increment
        if (advance) n_addr = r_addr + {8'd0, r_autoinc};
        // Drop the DMA length once a transfer ends or a DMA start finds no fill or copy mode
        if (finish_dma) begin
            n_mode_regs[REG_LEN_LO] = 8'd0;
            n_mode_regs[REG_LEN_HI] = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_word_pending <= 1'b0;
            r_byte_pending <= 1'b0;
            r_first        <= '0;
            r_addr         <= '0;
            r_code         <= '0;
            r_autoinc      <= 8'd2;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_mode_regs[i] <= (i == REG_MODE2) ? 8'h40 : 8'h00;
            end
            r_vcount       <= '0;
            r_in_vblank    <= 1'b0;
            r_vint         <= 1'b0;
            r_fill_armed   <= 1'b0;
            r_fill_word    <= '0;
            r_done         <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr          <= n_clr;
            r_word_pending <= n_word_pending;
            r_byte_pending <= n_byte_pending;
            r_first        <= n_first;
            r_addr         <= n_addr;
            r_code         <= n_code;
            r_autoinc      <= n_autoinc;
            r_mode_regs    <= n_mode_regs;
            r_vcount       <= n_vcount;
            r_in_vblank    <= n_in_vblank;
            r_vint         <= n_vint;
            r_fill_armed   <= n_fill_armed;
            r_fill_word    <= n_fill_word;
            r_done         <= n_done;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_src       <= n_src;
        r_byte_mode <= n_byte_mode;
        r_byte_odd  <= n_byte_odd;
        r_hi_byte   <= n_hi_byte;
        r_rd        <= n_rd;
        r_vs        <= n_vs;
        r_hi        <= n_hi;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_read_data    = r_rd;
    assign o_vblank_start = r_vs;
    assign o_hint_fire    = r_hi;

endmodule

FILE: sv/vdp_checker.sv
// Port-level checker for vdp_port_and_dma_engine, bound to the top level.
// Depends on vdp_pkg for command codes.
module vdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_cmd,
    input logic [4:0]  i_port_offset,
    input logic        o_done,
    input logic [15:0] o_read_data,
    input logic        o_vblank_start,
    input logic        o_hint_fire
);
    import vdp_pkg::*;

    // Reset starts the memory clearing pass
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // A result follows either an accepted item or a running sequence
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start)))
        else $error("result strobe without a cause");

    // Vblank start and H-interrupt exclude each other
    a_tick_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_vblank_start && o_hint_fire))
        else $error("vblank start and hint on the same tick");

    // An ignored word write finishes in the next cycle with a zero result
    a_ignored_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_WRITE_WORD && i_port_offset[4])
        |=> (o_done && o_read_data == 16'd0))
        else $error("ignored write did not finish at once");

endmodule

bind vdp_port_and_dma_engine vdp_checker u_vdp_checker (.*);

FILE: tb/vdp_port_and_dma_engine_test.sv
`timescale 1ns / 100ps
// Self-checking bench for vdp_port_and_dma_engine: random port, control and DMA traffic,
// each result checked against an in-bench port model. Depends on vdp_pkg and the RTL.
module vdp_port_and_dma_engine_test;
    import vdp_pkg::*;

    localparam int WATCHDOG_CYCLES = 1000000;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        logic [2:0]  cmd;
        logic [4:0]  port_offset;
        logic [15:0] write_value;
        logic [8:0]  line_number;
    } t_port_item;

    typedef struct {
        logic [15:0] read_data;
        logic        vblank_start;
        logic        hint_fire;
    } t_port_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_cmd = '0;
    logic [4:0]  i_port_offset = '0;
    logic [15:0] i_write_value = '0;
    logic [8:0]  i_line_number = '0;
    logic        o_done;
    logic [15:0] o_read_data;
    logic        o_vblank_start;
    logic        o_hint_fire;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    vdp_port_and_dma_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_port_offset  (i_port_offset),
        .i_write_value  (i_write_value),
        .i_line_number  (i_line_number),
        .o_done         (o_done),
        .o_read_data    (o_read_data),
        .o_vblank_start (o_vblank_start),
        .o_hint_fire    (o_hint_fire),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Port model state: configuration, command latch, memories, timing
    // ------------------------------------------------------------------
    logic        cfg_pal;
    logic [8:0]  cfg_lines_ntsc;
    logic [8:0]  cfg_lines_pal;

    logic        word_half_waiting;
    logic        byte_half_waiting;
    logic [15:0] latched_half;
    logic [15:0] vram_addr;
    logic [5:0]  vram_code;
    logic [7:0]  addr_step;
    logic [7:0]  mode_regs [REG_COUNT];
    logic [7:0]  vram_image [VRAM_BYTES];
    logic [15:0] cram_image [CRAM_DEPTH];
    logic [15:0] vsram_image [VSRAM_DEPTH];
    logic [7:0]  vcount;
    logic        vblank_now;
    logic        vint_pending;
    logic        fill_pending;
    logic [15:0] last_data_word;

    t_port_item   pending_items[$];
    t_port_result expected_results[$];

    int mismatch_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;

    task automatic reset_port_model();
        cfg_pal = 1'b0;
        cfg_lines_ntsc = 9'd224;
        cfg_lines_pal = 9'd240;
        word_half_waiting = 1'b0;
        byte_half_waiting = 1'b0;
        latched_half = '0;
        vram_addr = '0;
        vram_code = '0;
        addr_step = 8'd2;
        foreach (mode_regs[i]) mode_regs[i] = '0;
        mode_regs[REG_MODE2] = 8'h40;
        foreach (vram_image[i]) vram_image[i] = '0;
        foreach (cram_image[i]) cram_image[i] = '0;
        foreach (vsram_image[i]) vsram_image[i] = '0;
        vcount = '0;
        vblank_now = 1'b0;
        vint_pending = 1'b0;
        fill_pending = 1'b0;
        last_data_word = '0;
    endtask

    task automatic load_mode_reg(input logic [15:0] w);
        logic [4:0] r;
        r = w[12:8];
        if (r < REG_COUNT) begin
            mode_regs[r] = w[7:0];
            if (r == REG_AUTOINC) addr_step = w[7:0];
        end
    endtask

    // Fill or copy over the programmed length, then clear the length registers.
    task automatic run_dma_model();
        logic [1:0]  mode;
        logic [16:0] len;
        logic [15:0] src;
        mode = mode_regs[REG_DMA][7:6];
        len = {1'b0, mode_regs[REG_LEN_HI], mode_regs[REG_LEN_LO]};
        src = {mode_regs[REG_SRC_HI], mode_regs[REG_SRC_LO]};
        if (len == 0) len = 17'h10000;
        for (int i = 0; i < len; i++) begin
            if (mode == DMA_FILL) begin
                if (vram_code[3:0] == CODE_VRAM_WR) vram_image[vram_addr] = last_data_word[15:8];
                vram_addr = vram_addr + addr_step;
            end else if (mode == DMA_COPY) begin
                vram_image[vram_addr] = vram_image[src];
                src = src + 16'd1;
                vram_addr = vram_addr + addr_step;
            end
        end
        mode_regs[REG_LEN_LO] = '0;
        mode_regs[REG_LEN_HI] = '0;
    endtask

    task automatic data_write_model(input logic [15:0] v);
        last_data_word = v;
        if (fill_pending) begin
            fill_pending = 1'b0;
            run_dma_model();
        end else begin
            case (vram_code[3:0])
                CODE_VRAM_WR: begin
                    vram_image[vram_addr] = v[15:8];
                    vram_image[16'(vram_addr + 16'd1)] = v[7:0];
                end
                CODE_CRAM_WR:  cram_image[vram_addr[6:1]] = v;
                CODE_VSRAM_WR: vsram_image[vram_addr[6:1] & VSRAM_MASK] = v;
                default: ;
            endcase
            vram_addr = vram_addr + addr_step;
        end
    endtask

    task automatic word_read_model(input logic [4:0] off, output logic [15:0] v);
        logic [4:0] s;
        s = off & 5'h1E;
        v = 16'hFFFF;
        if (s == 0 || s == 2) begin
            case (vram_code[3:0])
                CODE_VRAM_RD:  v = {vram_image[vram_addr], vram_image[16'(vram_addr + 16'd1)]};
                CODE_CRAM_RD:  v = cram_image[vram_addr[6:1]];
                CODE_VSRAM_RD: v = vsram_image[vram_addr[6:1] & VSRAM_MASK];
                default:       v = '0;
            endcase
            vram_addr = vram_addr + addr_step;
        end else if (s == 4 || s == 6) begin
            // Status read: drop the interrupt flag and any half-written command.
            v = STATUS_BASE | {8'h00, vint_pending, 3'b000, vblank_now, 2'b00, cfg_pal};
            vint_pending = 1'b0;
            word_half_waiting = 1'b0;
            byte_half_waiting = 1'b0;
        end else if (s == 8) begin
            v = {vcount, 8'h00};
        end
    endtask

    task automatic predict_port_access(input t_port_item it, output t_port_result res);
        logic [15:0] w;
        logic [15:0] v;
        logic [8:0]  act;
        logic [4:0]  s;
        res = '{16'h0000, 1'b0, 1'b0};
        v = it.write_value;
        s = it.port_offset & 5'h1E;
        case (it.cmd)
            CMD_READ_BYTE: begin
                if (it.port_offset < 4) begin
                    word_read_model(it.port_offset & 5'h1E, w);
                    res.read_data = it.port_offset[0] ? {8'h00, w[7:0]} : {8'h00, w[15:8]};
                end else if (it.port_offset == 8) res.read_data = '0;
                else if (it.port_offset == 9) res.read_data = {8'h00, vcount};
                else res.read_data = 16'h00FF;
            end
            CMD_READ_WORD: begin
                word_read_model(it.port_offset, w);
                res.read_data = w;
            end
            CMD_WRITE_BYTE: begin
                if (it.port_offset < 2) begin
                    data_write_model(it.port_offset[0] ? {8'h00, v[7:0]} : {v[7:0], 8'h00});
                end else if (it.port_offset < 8) begin
                    // Pair two control bytes into one register write.
                    if (!byte_half_waiting) begin
                        latched_half = {8'h00, v[7:0]};
                        byte_half_waiting = 1'b1;
                    end else begin
                        byte_half_waiting = 1'b0;
                        w = {latched_half[7:0], v[7:0]};
                        if (w[15:14] == 2'b10) load_mode_reg(w);
                    end
                end
            end
            CMD_WRITE_WORD: begin
                if (s == 0 || s == 2) begin
                    data_write_model(v);
                end else if (s == 4 || s == 6) begin
                    if (word_half_waiting) begin
                        word_half_waiting = 1'b0;
                        vram_code = {v[7:4], latched_half[15:14]};
                        vram_addr = {v[1:0], latched_half[13:0]};
                        if (vram_code[5]) begin
                            if (mode_regs[REG_DMA][7:6] == DMA_FILL) fill_pending = 1'b1;
                            else run_dma_model();
                        end
                    end else if (v[15:14] == 2'b10) begin
                        load_mode_reg(v);
                    end else begin
                        latched_half = v;
                        word_half_waiting = 1'b1;
                    end
                end
            end
            CMD_TICK: begin
                act = cfg_pal ? cfg_lines_pal : cfg_lines_ntsc;
                vcount = it.line_number[7:0];
                vblank_now = it.line_number >= act;
                res.vblank_start = it.line_number == act;
                if (res.vblank_start) vint_pending = 1'b1;
                if (mode_regs[REG_MODE1][4] && it.line_number < act)
                    res.hint_fire = (it.line_number % (mode_regs[REG_HINT] + 1)) == 0;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of items from the pending queue, random gaps between
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_port_item   cur;
        t_port_result res;
        logic         drive_next;
        if (i_rst_n) begin
            drive_next = 1'b0;
            if (start && !busy) begin
                cur = '{i_cmd, i_port_offset, i_write_value, i_line_number};
                predict_port_access(cur, res);
                expected_results.push_back(res);
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() > 0) begin
                    cur = pending_items.pop_front();
                    drive_next = 1'b1;
                    i_cmd <= cur.cmd;
                    i_port_offset <= cur.port_offset;
                    i_write_value <= cur.write_value;
                    i_line_number <= cur.line_number;
                    if (burst_left <= 1) begin
                        // Alternate long no-gap stretches with short choppy ones.
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
                start <= drive_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_port_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: read_data=%h vblank=%b hint=%b",
                             o_read_data, o_vblank_start, o_hint_fire);
            end else begin
                want = expected_results.pop_front();
                if (o_read_data !== want.read_data || o_vblank_start !== want.vblank_start ||
                    o_hint_fire !== want.hint_fire) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch: read_data %h/%h vblank %b/%b hint %b/%b (exp/got)",
                                 want.read_data, o_read_data, want.vblank_start,
                                 o_vblank_start, want.hint_fire, o_hint_fire);
                end
            end
        end
    end

    // Watchdog: reset on any accepted item or result.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("vdp_port_and_dma_engine_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic [2:0] c, input logic [4:0] o, input logic [15:0] v,
                            input logic [8:0] l);
        pending_items.push_back('{c, o, v, l});
    endtask

    task automatic write_mode_reg(input logic [4:0] r, input logic [7:0] v);
        add_item(CMD_WRITE_WORD, 5'($urandom_range(4, 7)), {3'b100, r, v}, 9'($urandom));
    endtask

    task automatic read_status();
        add_item(CMD_READ_WORD, 5'($urandom_range(4, 7)), 16'($urandom), 9'($urandom));
    endtask

    // Two-word address/code command.
    task automatic set_access(input logic [5:0] code, input logic [15:0] a);
        add_item(CMD_WRITE_WORD, 5'($urandom_range(4, 7)), {code[1:0], a[13:0]},
                 9'($urandom));
        add_item(CMD_WRITE_WORD, 5'($urandom_range(4, 7)),
                 {8'($urandom), code[5:2], 2'($urandom), a[15:14]}, 9'($urandom));
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            CFG_PAL_MODE:   cfg_pal = v[0];
            CFG_LINES_NTSC: cfg_lines_ntsc = v[8:0];
            CFG_LINES_PAL:  cfg_lines_pal = v[8:0];
            default: ;
        endcase
    endtask

    // Hold until every queued item went in, every result came back and busy is low.
    task automatic drain();
        while (pending_items.size() > 0 || expected_results.size() > 0 || start)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [5:0] pick_code();
        logic [3:0] codes [6];
        codes = '{CODE_VRAM_RD, CODE_VRAM_WR, CODE_CRAM_WR, CODE_VSRAM_RD, CODE_VSRAM_WR,
                  CODE_CRAM_RD};
        if ($urandom_range(0, 9) == 0) return {2'b00, 4'($urandom)};
        return {2'b00, codes[$urandom_range(0, 5)]};
    endfunction

    task automatic add_random_items(input int count);
        logic [4:0]  r;
        logic [7:0]  v;
        logic [8:0]  act;
        int          kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            act = cfg_pal ? cfg_lines_pal : cfg_lines_ntsc;
            if (kind < 12) begin
                // Mode register write; keep DMA lengths short.
                read_status();
                r = 5'($urandom);
                v = 8'($urandom);
                if (r == REG_LEN_HI) v = 8'h00;
                if (r == REG_LEN_LO) v = 8'($urandom_range(1, 24));
                if (r == REG_HINT) v = 8'($urandom_range(0, 7));
                write_mode_reg(r, v);
            end else if (kind < 24) begin
                read_status();
                set_access(pick_code(), 16'($urandom));
            end else if (kind < 40) begin
                add_item(CMD_WRITE_WORD, 5'($urandom_range(0, 3)), 16'($urandom), 9'($urandom));
            end else if (kind < 46) begin
                add_item(CMD_WRITE_BYTE, 5'($urandom_range(0, 1)), 16'($urandom), 9'($urandom));
            end else if (kind < 60) begin
                add_item(CMD_READ_WORD, 5'($urandom_range(0, 3)), 16'($urandom), 9'($urandom));
            end else if (kind < 66) begin
                add_item(CMD_READ_BYTE, 5'($urandom), 16'($urandom), 9'($urandom));
            end else if (kind < 80) begin
                // Ticks cluster around the active line count.
                add_item(CMD_TICK, 5'($urandom),16'($urandom),
                         ($urandom_range(0, 1) == 0) ? 9'($urandom)
                                                     : 9'(act + $urandom_range(0, 4) - 2));
            end else if (kind < 86) begin
                // Short DMA: length, mode, command, and the data word a fill waits for.
                read_status();
                write_mode_reg(REG_LEN_LO, 8'($urandom_range(1, 24)));
                write_mode_reg(REG_LEN_HI, 8'h00);
                write_mode_reg(REG_SRC_LO, 8'($urandom));
                write_mode_reg(REG_SRC_HI, 8'($urandom));
                write_mode_reg(REG_DMA, {2'($urandom), 6'($urandom)});
                set_access({2'b10, 4'(($urandom_range(0, 3) == 0) ? $urandom : CODE_VRAM_WR)},
                           16'($urandom));
                add_item(CMD_WRITE_WORD, 5'($urandom_range(0, 3)), 16'($urandom), 9'($urandom));
            end else if (kind < 90) begin
                add_item(CMD_WRITE_BYTE, 5'($urandom_range(2, 7)), 16'($urandom), 9'($urandom));
            end else if (kind < 93) begin
                read_status();
            end else begin
                // Noise: any command and offset, no DMA bit on control words.
                add_item(3'($urandom), 5'($urandom), 16'($urandom) & 16'hFF7F, 9'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        reset_port_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: memories, edges of the fields, status, ticks, noise.
        write_mode_reg(REG_AUTOINC, 8'h02);
        set_access({2'b00, CODE_VRAM_WR}, 16'hFFFF);
        add_item(CMD_WRITE_WORD, 5'd0, 16'hFFFF, 9'h000);
        add_item(CMD_WRITE_BYTE, 5'd1, 16'hFFA5, 9'h1FF);
        set_access({2'b00, CODE_VRAM_RD}, 16'hFFFF);
        add_item(CMD_READ_WORD, 5'd2, 16'h0000, 9'h000);
        add_item(CMD_READ_BYTE, 5'd3, 16'h0000, 9'h000);
        set_access({2'b00, CODE_VSRAM_WR}, 16'h004E);
        add_item(CMD_WRITE_WORD, 5'd2, 16'h1234, 9'h000);
        set_access({2'b00, CODE_VSRAM_RD}, 16'h004E);
        add_item(CMD_READ_WORD, 5'd0, 16'h0000, 9'h000);
        add_item(CMD_READ_BYTE, 5'd9, 16'h0000, 9'h000);
        add_item(CMD_READ_WORD, 5'd31, 16'h0000, 9'h000);
        write_mode_reg(REG_MODE1, 8'h10);
        add_item(CMD_TICK, 5'd0, 16'h0000, 9'd224);
        add_item(CMD_TICK, 5'd0, 16'h0000, 9'd0);
        add_item(CMD_READ_WORD, 5'd4, 16'h0000, 9'h000);
        add_item(CMD_WRITE_BYTE, 5'd2, 16'h008F, 9'h000);
        add_item(CMD_WRITE_BYTE, 5'd7, 16'h0004, 9'h000);
        add_item(3'd7, 5'd31, 16'hFFFF, 9'h1FF);
        add_item(CMD_WRITE_WORD, 5'd8, 16'hFFFF, 9'h000);
        drain();

        // Full-length fill, then full-length copy (zero length means 65536).
        write_mode_reg(REG_LEN_LO, 8'h00);
        write_mode_reg(REG_LEN_HI, 8'h00);
        write_mode_reg(REG_DMA, 8'h80);
        set_access({2'b10, CODE_VRAM_WR}, 16'h0000);
        add_item(CMD_WRITE_WORD, 5'd0, 16'hC300, 9'h000);
        write_mode_reg(REG_AUTOINC, 8'h01);
        write_mode_reg(REG_DMA, 8'hC0);
        write_mode_reg(REG_SRC_LO, 8'h34);
        write_mode_reg(REG_SRC_HI, 8'h12);
        set_access({2'b10, CODE_VRAM_WR}, 16'h8000);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin cfg_write(CFG_PAL_MODE, 0); cfg_write(CFG_LINES_NTSC, 0); end
                1: begin cfg_write(CFG_PAL_MODE, 1); cfg_write(CFG_LINES_PAL, 511); end
                2: begin cfg_write(CFG_PAL_MODE, 0); cfg_write(CFG_LINES_NTSC, 511); end
                3: begin cfg_write(CFG_PAL_MODE, 1); cfg_write(CFG_LINES_PAL, 0); end
                default: begin
                    cfg_write(CFG_PAL_MODE, $urandom_range(0, 1));
                    cfg_write(CFG_LINES_NTSC, $urandom_range(0, 511));
                    cfg_write(CFG_LINES_PAL, $urandom_range(0, 511));
                end
            endcase
            add_random_items(128);
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("vdp_port_and_dma_engine_test: done, clean");
        else
            $display("vdp_port_and_dma_engine_test: done, errors");
        $finish;
    end

endmodule
